@@ hw/rtl/pfr_pkg.sv @@
// Shared types and constants for the process FIFO with removal by key.
package pfr_pkg;

  // Queue geometry and pid width.
  localparam int unsigned DEPTH = 16;
  localparam int unsigned PID_BITS = 16;
  localparam int unsigned IDX_BITS = $clog2(DEPTH);
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_POP    = 3'd1,
    MODE_REMOVE = 3'd2,
    MODE_SEARCH = 3'd3,
    MODE_READ   = 3'd4
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_NOTFOUND = 2'd3
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_SHIFT = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  // Input item.
  typedef struct packed {
    logic [2:0]          mode;
    logic [PID_BITS-1:0] key_pid;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [PID_BITS-1:0] result_pid;
    logic [1:0]          status;
    logic [CNT_BITS-1:0] entries_after;
  } out_item_t;

  // Status of the shared scan step unit, one entry per cycle.
  typedef struct packed {
    logic [CNT_BITS-1:0] nxt;
    logic                at_end;
    logic                hit;
  } scan_t;

endpackage

@@ hw/rtl/pfr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pfr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/pfr_scan_unit.sv @@
// Shared step unit: advances the entry pointer and compares one stored pid.
module pfr_scan_unit (
  input  logic [pfr_pkg::IDX_BITS-1:0] ptr_i,
  input  logic [pfr_pkg::CNT_BITS-1:0] count_i,
  input  logic [pfr_pkg::PID_BITS-1:0] rdata_i,
  input  logic [pfr_pkg::PID_BITS-1:0] key_i,
  input  logic                         take_first_i,
  output pfr_pkg::scan_t               scan_o
);

  // The next entry index and whether it runs past the last valid entry.
  assign scan_o.nxt    = pfr_pkg::CNT_BITS'(ptr_i) + pfr_pkg::CNT_BITS'(1);
  assign scan_o.at_end = (scan_o.nxt == count_i);

  // Pop and read take the oldest entry; the keyed operations need a pid match.
  assign scan_o.hit = take_first_i || (rdata_i == key_i);

endmodule

@@ hw/rtl/process_fifo_with_removal_unit.sv @@
// Top level of the bounded pid FIFO with append, pop, remove, search and read.
//
// Usage: one input item (mode, key_pid) enters on the in_valid_i/in_ready_o
// handshake, and exactly one result item (result_pid, status, entries_after)
// leaves on the out_valid_o/out_ready_i handshake, in the same order.
// Entries sit in a RAM in arrival order, slot 0 the oldest. A small
// sequencer walks the RAM one entry per cycle through a shared step unit.
// Read and pop find the oldest entry at once; search and remove compare
// one entry per cycle. Remove and pop then move every later entry down
// one slot, one per cycle.
// The block accepts one item at a time; in_ready_o is high only while
// the sequencer idles. A finished result moves into the output register,
// and the next item may be accepted while it waits there. If the receiver
// stalls and the output register is still full, the next result waits
// inside the sequencer, holding off further input.
// Reset empties the queue; the RAM contents are not cleared.
module process_fifo_with_removal_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pfr_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output pfr_pkg::out_item_t  out_data_o
);

  localparam int unsigned IdxBits = pfr_pkg::IDX_BITS;
  localparam int unsigned CntBits = pfr_pkg::CNT_BITS;
  localparam int unsigned PidBits = pfr_pkg::PID_BITS;

  pfr_pkg::state_e     st_q, st_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic [IdxBits-1:0]  ptr_q, ptr_d;
  logic [IdxBits-1:0]  wr_q, wr_d;
  logic [2:0]          mode_q, mode_d;
  logic [PidBits-1:0]  key_q, key_d;
  logic [PidBits-1:0]  res_pid_q, res_pid_d;
  pfr_pkg::status_e    res_st_q, res_st_d;
  logic                out_valid_q, out_valid_d;
  pfr_pkg::out_item_t  out_q, out_d;

  logic                ram_we;
  logic [IdxBits-1:0]  ram_waddr;
  logic [PidBits-1:0]  ram_wdata;
  logic                ram_re;
  logic [IdxBits-1:0]  ram_raddr;
  logic [PidBits-1:0]  ram_rdata;

  logic                is_append;
  logic                is_keyed;
  logic                is_remove;
  logic                take_first;
  pfr_pkg::scan_t      scan;

  // Operation decode; unused codes behave as read oldest.
  assign is_append  = (pfr_pkg::mode_e'(mode_q) == pfr_pkg::MODE_APPEND);
  assign is_keyed   = (pfr_pkg::mode_e'(mode_q) == pfr_pkg::MODE_REMOVE) ||
                      (pfr_pkg::mode_e'(mode_q) == pfr_pkg::MODE_SEARCH);
  assign is_remove  = (pfr_pkg::mode_e'(mode_q) == pfr_pkg::MODE_REMOVE) ||
                      (pfr_pkg::mode_e'(mode_q) == pfr_pkg::MODE_POP);
  assign take_first = !is_append && !is_keyed;

  // Entry store.
  pfr_ram #(
    .Width (PidBits),
    .Depth (pfr_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Shared pointer step and pid compare.
  pfr_scan_unit u_scan (
    .ptr_i        (ptr_q),
    .count_i      (cnt_q),
    .rdata_i      (ram_rdata),
    .key_i        (key_q),
    .take_first_i (take_first),
    .scan_o       (scan)
  );

  // Sequencer and output register next-state logic.
  always_comb begin
    st_d        = st_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    wr_d        = wr_q;
    mode_d      = mode_q;
    key_d       = key_q;
    res_pid_d   = res_pid_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = wr_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = scan.nxt[IdxBits-1:0];

    // The receiver takes the waiting result.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      pfr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          mode_d = in_data_i.mode;
          key_d  = in_data_i.key_pid;
          st_d   = pfr_pkg::ST_START;
        end
      end

      pfr_pkg::ST_START: begin
        res_pid_d = '0;
        st_d      = pfr_pkg::ST_DONE;
        if (is_append) begin
          if (cnt_q == CntBits'(pfr_pkg::DEPTH)) begin
            res_st_d = pfr_pkg::STATUS_FULL;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = cnt_q[IdxBits-1:0];
            ram_wdata = key_q;
            cnt_d     = cnt_q + CntBits'(1);
            res_pid_d = key_q;
            res_st_d  = pfr_pkg::STATUS_OK;
          end
        end else if (cnt_q == '0) begin
          res_st_d = is_keyed ? pfr_pkg::STATUS_NOTFOUND : pfr_pkg::STATUS_EMPTY;
        end else begin
          // Fetch the oldest entry and start the walk.
          ram_re    = 1'b1;
          ram_raddr = '0;
          ptr_d     = '0;
          st_d      = pfr_pkg::ST_SCAN;
        end
      end

      pfr_pkg::ST_SCAN: begin
        if (scan.hit) begin
          res_pid_d = ram_rdata;
          res_st_d  = pfr_pkg::STATUS_OK;
          if (!is_remove) begin
            st_d = pfr_pkg::ST_DONE;
          end else if (scan.at_end) begin
            cnt_d = cnt_q - CntBits'(1);
            st_d  = pfr_pkg::ST_DONE;
          end else begin
            // Close the gap: later entries move down one slot each.
            ram_re = 1'b1;
            wr_d   = ptr_q;
            ptr_d  = scan.nxt[IdxBits-1:0];
            st_d   = pfr_pkg::ST_SHIFT;
          end
        end else if (scan.at_end) begin
          res_pid_d = '0;
          res_st_d  = pfr_pkg::STATUS_NOTFOUND;
          st_d      = pfr_pkg::ST_DONE;
        end else begin
          ram_re = 1'b1;
          ptr_d  = scan.nxt[IdxBits-1:0];
        end
      end

      pfr_pkg::ST_SHIFT: begin
        // The entry read last cycle lands one slot lower.
        ram_we = 1'b1;
        if (scan.at_end) begin
          cnt_d = cnt_q - CntBits'(1);
          st_d  = pfr_pkg::ST_DONE;
        end else begin
          ram_re = 1'b1;
          wr_d   = ptr_q;
          ptr_d  = scan.nxt[IdxBits-1:0];
        end
      end

      pfr_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.result_pid    = res_pid_q;
          out_d.status        = res_st_q;
          out_d.entries_after = cnt_q;
          st_d                = pfr_pkg::ST_IDLE;
        end
      end

      default: begin
        st_d = pfr_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= pfr_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    wr_q      <= wr_d;
    mode_q    <= mode_d;
    key_q     <= key_d;
    res_pid_q <= res_pid_d;
    res_st_q  <= res_st_d;
    out_q     <= out_d;
  end

  assign in_ready_o  = (st_q == pfr_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // The entry count never exceeds the store depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntBits'(pfr_pkg::DEPTH))
    else $error("entry count above depth");

  // The count moves by at most one per item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |->
      ((cnt_q == $past(cnt_q) + CntBits'(1)) || (cnt_q == $past(cnt_q) - CntBits'(1))))
    else $error("entry count jumped");

  // Only an append writes at or beyond the current count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> ((CntBits'(ram_waddr) < cnt_q) || (st_q == pfr_pkg::ST_START)))
    else $error("store written outside the valid entries");

  // A failed operation reports a zero pid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != pfr_pkg::STATUS_OK)) |->
      (out_data_o.result_pid == '0))
    else $error("nonzero pid with failing status");

  // An accepted item starts the sequencer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (st_q == pfr_pkg::ST_START))
    else $error("accepted item not started");
`endif

endmodule
